@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// Each check is sampled on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("%m: check failed");

`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_IMPLIES(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/tsd_pkg.sv @@
package tsd_pkg;

	// Number of odd Taylor terms in the series.
	localparam int TERMS = 17;

	localparam logic [16:0] ANGLE_MAX = 17'd92160;

	// pi/180 in units of 2^-46, rounded from floor(pi * 2^60).
	localparam longint unsigned PI60 = 64'h3243F6A8885A308D;
	localparam longint unsigned KDIV = 64'd2949120;
	localparam logic [40:0] KRAD = 41'((PI60 + KDIV / 64'd2) / KDIV);

	localparam logic signed [47:0] Q40_ONE = 48'sh0100_0000_0000;
	localparam logic signed [47:0] Q40_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic [30:0] Q30_MAX = 31'h7FFF_FFFF;

	localparam longint unsigned ONE_U = 64'd1099511627776;

	// Reciprocal factorial ratios 1/((2k)(2k+1)) in Q8.40, rounded to nearest.
	localparam logic signed [47:0] RATIO [0:23] = '{
		48'sd0,
		48'((ONE_U + 64'd3) / 64'd6),
		48'((ONE_U + 64'd10) / 64'd20),
		48'((ONE_U + 64'd21) / 64'd42),
		48'((ONE_U + 64'd36) / 64'd72),
		48'((ONE_U + 64'd55) / 64'd110),
		48'((ONE_U + 64'd78) / 64'd156),
		48'((ONE_U + 64'd105) / 64'd210),
		48'((ONE_U + 64'd136) / 64'd272),
		48'((ONE_U + 64'd171) / 64'd342),
		48'((ONE_U + 64'd210) / 64'd420),
		48'((ONE_U + 64'd253) / 64'd506),
		48'((ONE_U + 64'd300) / 64'd600),
		48'((ONE_U + 64'd351) / 64'd702),
		48'((ONE_U + 64'd406) / 64'd812),
		48'((ONE_U + 64'd465) / 64'd930),
		48'((ONE_U + 64'd528) / 64'd1056),
		48'((ONE_U + 64'd595) / 64'd1190),
		48'((ONE_U + 64'd666) / 64'd1332),
		48'((ONE_U + 64'd741) / 64'd1482),
		48'((ONE_U + 64'd820) / 64'd1640),
		48'((ONE_U + 64'd903) / 64'd1806),
		48'((ONE_U + 64'd990) / 64'd1980),
		48'((ONE_U + 64'd1081) / 64'd2162)
	};

	typedef logic signed [17:0] tsd_angle_t;
	typedef logic signed [31:0] tsd_sine_t;

	// Values that ride along with a product through the multiplier pipeline.
	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
	} tsd_side_t;

	typedef struct packed {
		logic               valid;
		logic signed [47:0] a;
		logic signed [47:0] b;
		tsd_side_t          side;
	} tsd_mul_in_t;

	typedef struct packed {
		logic               valid;
		logic signed [47:0] p;
		tsd_side_t          side;
	} tsd_mul_out_t;

endpackage

@@ design/tsd_angle_if.sv @@
interface tsd_angle_if import tsd_pkg::*; ();
	logic       valid;
	logic       ready;
	tsd_angle_t angle_deg;

	modport source (output valid, output angle_deg, input ready);
	modport sink (input valid, input angle_deg, output ready);
endinterface

@@ design/tsd_sine_if.sv @@
interface tsd_sine_if import tsd_pkg::*; ();
	logic      valid;
	logic      ready;
	tsd_sine_t sine_value;

	modport source (output valid, output sine_value, input ready);
	modport sink (input valid, input sine_value, output ready);
endinterface

@@ design/tsd_qmul.sv @@
// Four-stage Q8.40 multiplier: sign and magnitude, 24-bit partial products,
// summation with rounding, then saturation and sign.
module tsd_qmul import tsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  tsd_mul_in_t  din,
	output tsd_mul_out_t dout
);

	localparam logic [95:0] RND40 = 96'd1 << 39;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        neg_s1, neg_s2, neg_s3;
	logic [47:0] ua_s1, ub_s1;
	logic [47:0] pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [55:0] rnd_s3;
	logic signed [47:0] p_s4;
	tsd_side_t   side_s1, side_s2, side_s3, side_s4;

	logic [95:0] sum;
	logic [46:0] qmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= din.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign sum = {pp_hh_s2, 48'd0} + {24'd0, pp_lh_s2, 24'd0} + {24'd0, pp_hl_s2, 24'd0}
		+ {48'd0, pp_ll_s2} + RND40;

	assign qmag = (rnd_s3 > 56'(Q40_MAX)) ? Q40_MAX[46:0] : rnd_s3[46:0];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= din.a[47] ^ din.b[47];
			ua_s1    <= din.a[47] ? $unsigned(-din.a) : $unsigned(din.a);
			ub_s1    <= din.b[47] ? $unsigned(-din.b) : $unsigned(din.b);
			side_s1  <= din.side;

			pp_ll_s2 <= ua_s1[23:0] * ub_s1[23:0];
			pp_lh_s2 <= ua_s1[23:0] * ub_s1[47:24];
			pp_hl_s2 <= ua_s1[47:24] * ub_s1[23:0];
			pp_hh_s2 <= ua_s1[47:24] * ub_s1[47:24];
			neg_s2   <= neg_s1;
			side_s2  <= side_s1;

			rnd_s3   <= sum[95:40];
			neg_s3   <= neg_s2;
			side_s3  <= side_s2;

			p_s4     <= neg_s3 ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			side_s4  <= side_s3;
		end
	end

	assign dout.valid = valid_s4;
	assign dout.p     = p_s4;
	assign dout.side  = side_s4;

endmodule

@@ design/taylor_sine_from_degrees.sv @@
// Sine of an angle given in degrees, by a Taylor series in Horner form.
// The angle channel carries angle_deg, signed with 8 fraction bits of a degree;
// values beyond plus or minus 360 degrees are clamped to that bound. The sine
// channel returns sine_value in signed Q2.30, one item for every angle item.
// Both channels use valid and ready; an item moves on an edge where both are high.
// The datapath is one long pipeline: four stages turn the angle into radians in
// Q8.40, a four-stage multiplier forms x squared, each of the TERMS-1 Horner
// steps takes nine stages (two multipliers and a subtract), a last multiplier
// forms x times the sum and two stages round the result to Q2.30.
// One item enters every cycle while angle.ready is high; the 24-bit partial
// product multipliers set the stage depth.
// When the receiver stalls, the finished item waits in the output register and
// the pipeline keeps moving as long as its last stage holds no item, which
// closes up gaps; once an item reaches that stage behind a waiting result,
// every stage holds and ready drops. Nothing is lost or repeated.
// Reset clears all valid bits, so the block comes up empty and ready.
`include "assert_macros.svh"

module taylor_sine_from_degrees import tsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	tsd_angle_if.sink    angle,
	tsd_sine_if.source   sine
);

	// Pipeline advance: the output register can take an item, or the last
	// internal stage is empty so shifting loses nothing.
	logic out_load;
	logic en_pipe;

	// Angle to radians.
	logic        ang_neg;
	logic [17:0] ang_abs;
	logic [16:0] ang_mag;
	logic [57:0] ang_sum;

	logic               ang_valid_s1, ang_valid_s2, ang_valid_s3, ang_valid_s4;
	logic               ang_neg_s1, ang_neg_s2, ang_neg_s3;
	logic [16:0]        ang_mag_s1;
	logic [37:0]        ang_pl_s2;
	logic [36:0]        ang_ph_s2;
	logic [43:0]        ang_m_s3;
	logic signed [47:0] ang_x_s4;

	// x squared and the Horner chain. Entry j holds the accumulator that
	// step j consumes; the last entry feeds the final multiplier.
	tsd_mul_in_t  y_in;
	tsd_mul_out_t y_out;
	tsd_mul_out_t acc_chain [0:TERMS-1];

	// Final product and rounding to Q2.30.
	tsd_mul_in_t  fin_in;
	tsd_mul_out_t fin_out;
	logic [47:0]  fin_mag;
	logic [48:0]  fin_rsum;
	logic [30:0]  fin_m30;

	logic         fin_valid_s1;
	logic         fin_neg_s1;
	logic [38:0]  fin_rm_s1;

	logic         sine_valid_q;
	tsd_sine_t    sine_value_q;

	assign out_load    = !sine_valid_q || sine.ready;
	assign en_pipe     = out_load || !fin_valid_s1;
	assign angle.ready = en_pipe;

	// Clamp on the magnitude: |a| above the bound is the same as a beyond it.
	assign ang_neg = angle.angle_deg[17];
	assign ang_abs = ang_neg ? $unsigned(-angle.angle_deg) : $unsigned(angle.angle_deg);
	assign ang_mag = (ang_abs > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : ang_abs[16:0];

	// Magnitude times pi/180 rounded at 14 bits; the result stays well inside
	// Q8.40, so no saturation is needed here.
	assign ang_sum = {ang_ph_s2, 21'd0} + 58'(ang_pl_s2) + (58'd1 << 13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_valid_s1 <= 1'b0;
			ang_valid_s2 <= 1'b0;
			ang_valid_s3 <= 1'b0;
			ang_valid_s4 <= 1'b0;
		end else if (en_pipe) begin
			ang_valid_s1 <= angle.valid;
			ang_valid_s2 <= ang_valid_s1;
			ang_valid_s3 <= ang_valid_s2;
			ang_valid_s4 <= ang_valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_pipe) begin
			ang_neg_s1 <= ang_neg;
			ang_mag_s1 <= ang_mag;

			ang_pl_s2  <= ang_mag_s1 * KRAD[20:0];
			ang_ph_s2  <= ang_mag_s1 * KRAD[40:21];
			ang_neg_s2 <= ang_neg_s1;

			ang_m_s3   <= ang_sum[57:14];
			ang_neg_s3 <= ang_neg_s2;

			ang_x_s4   <= ang_neg_s3 ? -$signed({4'd0, ang_m_s3}) : $signed({4'd0, ang_m_s3});
		end
	end

	assign y_in.valid  = ang_valid_s4;
	assign y_in.a      = ang_x_s4;
	assign y_in.b      = ang_x_s4;
	assign y_in.side.x = ang_x_s4;
	assign y_in.side.y = '0;

	tsd_qmul u_mul_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en_pipe),
		.din    (y_in),
		.dout   (y_out)
	);

	// The innermost Horner level starts from one.
	assign acc_chain[0].valid  = y_out.valid;
	assign acc_chain[0].p      = Q40_ONE;
	assign acc_chain[0].side.x = y_out.side.x;
	assign acc_chain[0].side.y = y_out.p;

	for (genvar j = 0; j < TERMS - 1; j++) begin : g_step
		// Step j uses the ratio of term TERMS-1-j: acc = 1 - (y*acc) * R[k].
		localparam int K = TERMS - 1 - j;

		tsd_mul_in_t        ma_in, mb_in;
		tsd_mul_out_t       ma_out, mb_out;
		logic signed [48:0] diff;
		logic               sub_valid_s9;
		logic signed [47:0] sub_acc_s9;
		tsd_side_t          sub_side_s9;

		assign ma_in.valid = acc_chain[j].valid;
		assign ma_in.a     = acc_chain[j].side.y;
		assign ma_in.b     = acc_chain[j].p;
		assign ma_in.side  = acc_chain[j].side;

		tsd_qmul u_mul_a (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en_pipe),
			.din    (ma_in),
			.dout   (ma_out)
		);

		assign mb_in.valid = ma_out.valid;
		assign mb_in.a     = ma_out.p;
		assign mb_in.b     = RATIO[K];
		assign mb_in.side  = ma_out.side;

		tsd_qmul u_mul_b (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en_pipe),
			.din    (mb_in),
			.dout   (mb_out)
		);

		assign diff = 49'(Q40_ONE) - 49'(mb_out.p);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sub_valid_s9 <= 1'b0;
			end else if (en_pipe) begin
				sub_valid_s9 <= mb_out.valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en_pipe) begin
				if (diff > 49'(Q40_MAX)) begin
					sub_acc_s9 <= Q40_MAX;
				end else if (diff < -49'(Q40_MAX)) begin
					sub_acc_s9 <= -Q40_MAX;
				end else begin
					sub_acc_s9 <= diff[47:0];
				end
				sub_side_s9 <= mb_out.side;
			end
		end

		assign acc_chain[j+1].valid = sub_valid_s9;
		assign acc_chain[j+1].p     = sub_acc_s9;
		assign acc_chain[j+1].side  = sub_side_s9;
	end

	assign fin_in.valid = acc_chain[TERMS-1].valid;
	assign fin_in.a     = acc_chain[TERMS-1].side.x;
	assign fin_in.b     = acc_chain[TERMS-1].p;
	assign fin_in.side  = acc_chain[TERMS-1].side;

	tsd_qmul u_mul_fin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en_pipe),
		.din    (fin_in),
		.dout   (fin_out)
	);

	// Round the magnitude at 10 bits, then saturate and restore the sign.
	assign fin_mag  = fin_out.p[47] ? $unsigned(-fin_out.p) : $unsigned(fin_out.p);
	assign fin_rsum = {1'b0, fin_mag} + 49'd512;
	assign fin_m30  = (fin_rm_s1 > 39'(Q30_MAX)) ? Q30_MAX : fin_rm_s1[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (en_pipe) begin
			fin_valid_s1 <= fin_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_pipe) begin
			fin_rm_s1  <= fin_rsum[48:10];
			fin_neg_s1 <= fin_out.p[47];
		end
	end

	// Output register: loads only when empty or when its item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_valid_q <= 1'b0;
		end else if (out_load) begin
			sine_valid_q <= fin_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sine_value_q <= fin_neg_s1 ? -$signed({1'b0, fin_m30}) : $signed({1'b0, fin_m30});
		end
	end

	assign sine.valid      = sine_valid_q;
	assign sine.sine_value = sine_value_q;

	// An empty output register never holds back the input side.
	`ASSERT_IMPLIES(a_ready_when_empty, !sine.valid, angle.ready)
	// A finished item in the last stage reaches the output when there is room.
	`ASSERT_NEXT(a_fin_reaches_out, fin_valid_s1 && (!sine.valid || sine.ready), sine.valid)
	// A square is never negative.
	`ASSERT_IMPLIES(a_square_sign, y_out.valid, !y_out.p[47])

endmodule

@@ tb/sv/taylor_sine_from_degrees_test.sv @@
`timescale 1ns / 100ps

// Self-checking test of the degree-input Taylor sine pipeline. Angle items are
// driven at the falling clock edge from a queue filled up front, and sine items
// are sampled at the rising edge. Every accepted angle goes through a software
// model of the fixed-point series, and its result waits in a queue. The
// returned sine items are compared against that queue in order.
module taylor_sine_from_degrees_test;
	import tsd_pkg::*;

	// Fixed-point constants of the series, kept independent of the design.
	localparam int SERIES_TERMS = 17;
	localparam int ANGLE_LIMIT = 92160;
	localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
	localparam longint unsigned DEG_DIV = 64'd2949120;
	localparam longint unsigned RAD_PER_DEG = (PI_Q60 + DEG_DIV / 64'd2) / DEG_DIV;
	localparam longint ONE_Q40 = 64'sh0000_0100_0000_0000;
	localparam longint MAX_Q40 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint unsigned MAX_Q30 = 64'd2147483647;

	// Run control. The drain time is set above the pipeline depth, and the
	// watchdog well above that depth plus the long receiver hold-off.
	localparam int RANDOM_ANGLES = 900;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int HOLD_OFF_AFTER = 300;
	localparam int DRAIN_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		tsd_angle_t angle;
		tsd_sine_t  sine;
	} sine_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tsd_angle_if angle_ch ();
	tsd_sine_if sine_ch ();

	taylor_sine_from_degrees DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.angle  (angle_ch),
		.sine   (sine_ch)
	);

	always #5 clk = ~clk;

	tsd_angle_t pending_angles [$];
	sine_case_t expected_sines [$];

	int  angle_total = 0;
	int  angles_sent = 0;
	int  results_seen = 0;
	int  errors = 0;
	int  idle_cycles = 0;
	int  angle_gap = 0;
	int  sine_wait = 0;
	bit  angle_quiet = 1'b0;
	bit  sine_quiet = 1'b0;
	bit  held_off_done = 1'b0;
	// Handshakes seen at the last rising edge, read by the falling-edge drivers.
	logic angle_hs = 1'b0;
	logic sine_hs = 1'b0;

	// Saturate to the symmetric Q8.40 range.
	function automatic longint clip_q40(longint v);
		if (v > MAX_Q40)
			return MAX_Q40;
		if (v < -MAX_Q40)
			return -MAX_Q40;
		return v;
	endfunction

	// Q8.40 product: exact magnitude product, rounded to nearest with ties away
	// from zero, saturated, then given the sign of the product.
	function automatic longint mul_q40(longint a, longint b);
		logic [95:0] prod;
		logic [96:0] rounded;
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned q;
		bit neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		prod = 96'(ua) * 96'(ub);
		rounded = ({1'b0, prod} + (97'd1 << 39)) >> 40;
		if (rounded > 97'(MAX_Q40))
			q = MAX_Q40;
		else
			q = rounded[63:0];
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// Ratio 1/((2k)(2k+1)) in Q8.40, rounded to nearest.
	function automatic longint fact_ratio_q40(int k);
		longint unsigned d;
		d = longint'(2 * k) * longint'(2 * k + 1);
		return longint'((64'd1099511627776 + d / 64'd2) / d);
	endfunction

	function automatic tsd_sine_t sine_of_angle(tsd_angle_t deg);
		int a;
		longint unsigned mag;
		longint x;
		longint y;
		longint acc;
		longint s;
		longint t;
		a = int'(deg);
		if (a > ANGLE_LIMIT)
			a = ANGLE_LIMIT;
		if (a < -ANGLE_LIMIT)
			a = -ANGLE_LIMIT;
		mag = longint'((a < 0) ? -a : a);
		mag = (mag * RAD_PER_DEG + 64'd8192) >> 14;
		x = (a < 0) ? -longint'(mag) : longint'(mag);
		x = clip_q40(x);
		// Horner steps in x squared, innermost term first.
		y = mul_q40(x, x);
		acc = ONE_Q40;
		for (int k = SERIES_TERMS - 1; k >= 1; k--) begin
			t = mul_q40(mul_q40(y, acc), fact_ratio_q40(k));
			acc = clip_q40(ONE_Q40 - t);
		end
		s = mul_q40(x, acc);
		mag = (s < 0) ? -s : s;
		mag = (mag + 64'd512) >> 10;
		if (mag > MAX_Q30)
			mag = MAX_Q30;
		return tsd_sine_t'((s < 0) ? -longint'(mag) : longint'(mag));
	endfunction

	// Per-item wait for either side. A quiet stretch gives back-to-back items;
	// the stretch flips now and then so both modes show up during the run.
	function automatic int draw_wait(ref bit quiet);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	// Angle sender. The current item stays on the bus until it is taken; once
	// the slot is free, the sender either idles out its drawn gap or puts up the
	// next angle in the same step, so valid never drops between back-to-back items.
	always @(negedge clk) begin
		if (!arst_n) begin
			angle_ch.valid <= 1'b0;
		end else if (!angle_ch.valid || angle_hs) begin
			if (angle_gap > 0) begin
				angle_gap = angle_gap - 1;
				angle_ch.valid <= 1'b0;
			end else if (pending_angles.size() > 0) begin
				angle_ch.angle_deg <= pending_angles.pop_front();
				angle_ch.valid <= 1'b1;
				angle_gap = draw_wait(angle_quiet);
			end else begin
				angle_ch.valid <= 1'b0;
			end
		end
	end

	// Sine receiver. After each taken result it draws how long to hold ready low.
	// Once, partway through, it holds off for a long stretch so the pipeline
	// fills and the block has to push back on the angle side.
	always @(negedge clk) begin
		if (!arst_n) begin
			sine_ch.ready <= 1'b0;
		end else begin
			if (sine_hs) begin
				sine_wait = draw_wait(sine_quiet);
				if (!held_off_done && results_seen >= HOLD_OFF_AFTER) begin
					sine_wait = HOLD_OFF_CYCLES;
					held_off_done = 1'b1;
				end
			end
			if (sine_wait > 0) begin
				sine_wait = sine_wait - 1;
				sine_ch.ready <= 1'b0;
			end else begin
				sine_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on every taken angle, checks every taken sine in order,
	// and keeps the watchdog on cycles where neither channel moves an item.
	always @(posedge clk) begin : monitor
		sine_case_t want;
		angle_hs <= arst_n && angle_ch.valid && angle_ch.ready;
		sine_hs <= arst_n && sine_ch.valid && sine_ch.ready;
		if (arst_n) begin
			if (angle_ch.valid && angle_ch.ready) begin
				expected_sines.push_back('{angle: angle_ch.angle_deg,
					sine: sine_of_angle(angle_ch.angle_deg)});
				angles_sent++;
			end
			if (sine_ch.valid && sine_ch.ready) begin
				results_seen++;
				if (expected_sines.size() == 0) begin
					errors++;
					$display("%0t: unexpected sine item %0d, nothing expected",
						$time, sine_ch.sine_value);
				end else begin
					want = expected_sines.pop_front();
					if (sine_ch.sine_value !== want.sine) begin
						errors++;
						$display("%0t: sine_value for angle %0d: expected %0d, actual %0d",
							$time, want.angle, want.sine, sine_ch.sine_value);
					end
				end
			end
			if ((angle_ch.valid && angle_ch.ready) || (sine_ch.valid && sine_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired with %0d results outstanding",
					$time, expected_sines.size());
				$display("taylor_sine_from_degrees_test NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		tsd_angle_t directed [] = '{
			18'sd0, 18'sd1, -18'sd1, 18'sd255, 18'sd256, -18'sd256,
			18'sd7680, 18'sd11520, 18'sd23040, -18'sd23040,
			18'sd46080, -18'sd46080, 18'sd69120, -18'sd69120,
			18'sd92159, -18'sd92159, 18'sd92160, -18'sd92160,
			18'sd92161, -18'sd92161, 18'sd131071, -18'sd131072
		};
		int pick;
		int a;
		angle_ch.valid = 1'b0;
		angle_ch.angle_deg = '0;
		sine_ch.ready = 1'b0;

		// Directed part: zero, the smallest steps, the quarter turns, both
		// clamp bounds with their neighbours, and the extremes of the field.
		foreach (directed[i])
			pending_angles.push_back(directed[i]);

		// Random part: mostly legal angles, some raw 18-bit words that exercise
		// the clamp and every bit, and some points close to multiples of 45
		// degrees where the series peaks, crosses zero or saturates.
		for (int i = 0; i < RANDOM_ANGLES; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 13)
				a = int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
			else if (pick < 16)
				a = tsd_angle_t'($urandom);
			else
				a = (int'($urandom_range(0, 16)) - 8) * 11520
					+ int'($urandom_range(0, 64)) - 32;
			pending_angles.push_back(tsd_angle_t'(a));
		end
		angle_total = pending_angles.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Run until every angle is taken and every sine has come back, then let
		// the pipeline run empty to catch any stray item.
		while (angles_sent < angle_total || expected_sines.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("taylor_sine_from_degrees_test OK");
		else
			$display("taylor_sine_from_degrees_test NOT OK");
		$finish;
	end

endmodule
